FILE: rtl/ocu_pkg.sv
// ----------------------------------------------------------------------------
// ocu_pkg: orbit camera update, shared types and constants
// Widths, fixed-point constants, register and step codes, payload structs.
// ----------------------------------------------------------------------------
package ocu_pkg;

	localparam int ANGLE_BITS   = 24;
	localparam int RADIUS_BITS  = 32;
	localparam int TURN_SHIFT   = 32 - ANGLE_BITS;
	localparam int START_ANG_W  = 24;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_AZ  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_DEC = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_RAD = 2'd2;

	// item function codes
	localparam logic FUNC_MOVE   = 1'b0;
	localparam logic FUNC_RELOAD = 1'b1;

	// register reset values
	localparam logic [START_ANG_W-1:0] START_AZ_RST  = 24'd0;
	localparam logic [START_ANG_W-1:0] START_DEC_RST = 24'd4194304;
	localparam logic signed [31:0]     START_RAD_RST = 32'sd655360;

	// CORDIC
	localparam int CORDIC_STEPS = 30;
	localparam int STEP_W       = 5;
	localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

	// 0.01 rad and 3.141 rad as binary angles, rounded half up
	localparam longint unsigned SPIN_UNIT_L =
		(((64'd6835653 << 1) >> TURN_SHIFT) + 64'd1) >> 1;
	localparam longint unsigned DEC_MAX_L =
		(((64'd2147078531 << 1) >> TURN_SHIFT) + 64'd1) >> 1;
	localparam logic [ANGLE_BITS-1:0] SPIN_UNIT = ANGLE_BITS'(SPIN_UNIT_L);

	localparam int DEC_W = ((ANGLE_BITS > START_ANG_W) ? ANGLE_BITS : START_ANG_W) + 2;
	localparam logic signed [DEC_W-1:0] DEC_MAX = DEC_W'(DEC_MAX_L);

	// radius arithmetic
	localparam int RSUM_W = ((RADIUS_BITS > 32) ? RADIUS_BITS : 32) + 1;
	localparam longint RAD_MAX_L = (64'sd1 <<< (RADIUS_BITS - 1)) - 64'sd1;
	localparam longint RAD_MIN_L = -RAD_MAX_L - 64'sd1;

	// multiplier widths
	localparam int RS_W  = RADIUS_BITS + 1;
	localparam int MA_W  = (RADIUS_BITS + 1 > 32) ? RADIUS_BITS + 1 : 32;
	localparam int P_W   = MA_W + 32;
	localparam int Q_W   = P_W - 30;
	localparam int DIR_W = P_W - 45 + 1;

	// product step codes, also the result tags
	localparam logic [2:0] MT_RS = 3'd0;
	localparam logic [2:0] MT_PZ = 3'd1;
	localparam logic [2:0] MT_DX = 3'd2;
	localparam logic [2:0] MT_DY = 3'd3;
	localparam logic [2:0] MT_PX = 3'd4;
	localparam logic [2:0] MT_PY = 3'd5;

	typedef struct packed {
		logic               func;
		logic signed [23:0] delta_declination;
		logic signed [23:0] delta_azimuth;
		logic signed [31:0] delta_radius;
		logic signed [15:0] spin_step;
	} req_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic               radius_zero;
	} rsp_t;

	typedef struct packed {
		logic       go;
		logic [2:0] tag;
		logic       neg;
	} mul_op_t;

	typedef struct packed {
		logic                  valid;
		logic [2:0]            tag;
		logic signed [Q_W-1:0] q30;
		logic signed [15:0]    dir;
	} mul_res_t;

	// arctangent of 2^-i in 2^32 units per turn
	function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
		logic [31:0] v;
		unique case (i)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			5'd24: v = 32'd41;
			5'd25: v = 32'd20;
			5'd26: v = 32'd10;
			5'd27: v = 32'd5;
			5'd28: v = 32'd3;
			5'd29: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	// clamp to the radius range
	function automatic logic signed [RADIUS_BITS-1:0] sat_radius(
		input logic signed [RSUM_W-1:0] v);
		logic signed [RADIUS_BITS-1:0] r;
		if (v > RSUM_W'(RAD_MAX_L)) begin
			r = RADIUS_BITS'(RAD_MAX_L);
		end else if (v < RSUM_W'(RAD_MIN_L)) begin
			r = RADIUS_BITS'(RAD_MIN_L);
		end else begin
			r = v[RADIUS_BITS-1:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/ocu_state.sv
// ----------------------------------------------------------------------------
// ocu_state: camera coordinate state
// Start registers, spherical state and the move/reload update.
// ----------------------------------------------------------------------------
module ocu_state (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [ocu_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ocu_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  capture,
	input  ocu_pkg::req_t                         req_data,
	input  logic                                  apply,
	output logic [ocu_pkg::ANGLE_BITS-1:0]        azimuth,
	output logic [ocu_pkg::ANGLE_BITS-1:0]        declination,
	output logic signed [ocu_pkg::RADIUS_BITS-1:0] radius
);
	import ocu_pkg::*;

	logic [START_ANG_W-1:0]        start_az_q;
	logic [START_ANG_W-1:0]        start_dec_q;
	logic signed [31:0]            start_rad_q;
	logic [ANGLE_BITS-1:0]         az_q;
	logic [ANGLE_BITS-1:0]         dec_q;
	logic [ANGLE_BITS-1:0]         spin_q;
	logic signed [RADIUS_BITS-1:0] rad_q;
	req_t                          item_q;
	logic [ANGLE_BITS-1:0]         spin_prod_q;

	logic signed [16+ANGLE_BITS:0] spin_mul;
	logic [ANGLE_BITS-1:0]         spin_n;
	logic [ANGLE_BITS-1:0]         az_n;
	logic signed [DEC_W-1:0]       dec_sum;
	logic [ANGLE_BITS-1:0]         dec_n;
	logic signed [RADIUS_BITS-1:0] rad_n;
	logic signed [RADIUS_BITS-1:0] rad_ld;

	assign spin_mul = req_data.spin_step * signed'({1'b0, SPIN_UNIT});

	always_comb begin
		spin_n  = spin_q + spin_prod_q;
		az_n    = az_q + ANGLE_BITS'(item_q.delta_azimuth) + spin_n;
		dec_sum = DEC_W'(signed'({1'b0, dec_q})) + DEC_W'(item_q.delta_declination);
		priority if (dec_sum < 0) begin
			dec_n = SPIN_UNIT;
		end else if (dec_sum > DEC_MAX) begin
			dec_n = DEC_MAX[ANGLE_BITS-1:0];
		end else begin
			dec_n = dec_sum[ANGLE_BITS-1:0];
		end
		rad_n  = sat_radius(RSUM_W'(rad_q) - RSUM_W'(item_q.delta_radius));
		rad_ld = sat_radius(RSUM_W'(start_rad_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_az_q  <= START_AZ_RST;
			start_dec_q <= START_DEC_RST;
			start_rad_q <= START_RAD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_AZ:  start_az_q  <= cfg_data[START_ANG_W-1:0];
				REG_START_DEC: start_dec_q <= cfg_data[START_ANG_W-1:0];
				REG_START_RAD: start_rad_q <= signed'(cfg_data[31:0]);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			az_q   <= ANGLE_BITS'(START_AZ_RST);
			dec_q  <= ANGLE_BITS'(START_DEC_RST);
			rad_q  <= sat_radius(RSUM_W'(START_RAD_RST));
			spin_q <= '0;
		end else if (apply) begin
			if (item_q.func == FUNC_RELOAD) begin
				az_q   <= ANGLE_BITS'(start_az_q);
				dec_q  <= ANGLE_BITS'(start_dec_q);
				rad_q  <= rad_ld;
				spin_q <= '0;
			end else begin
				az_q   <= az_n;
				dec_q  <= dec_n;
				rad_q  <= rad_n;
				spin_q <= spin_n;
			end
		end
	end

	// item hold, spin increment prepared at accept
	always_ff @(posedge clk) begin
		if (capture) begin
			item_q      <= req_data;
			spin_prod_q <= spin_mul[ANGLE_BITS-1:0];
		end
	end

	assign azimuth     = az_q;
	assign declination = dec_q;
	assign radius      = rad_q;

endmodule

FILE: rtl/ocu_cordic.sv
// ----------------------------------------------------------------------------
// ocu_cordic: iterative sine/cosine
// One rotation step per cycle, 30 steps, Q1.30 results.
// ----------------------------------------------------------------------------
module ocu_cordic (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ocu_pkg::ANGLE_BITS-1:0] angle,
	output logic                           done,
	output logic signed [31:0]             cos_v,
	output logic signed [31:0]             sin_v
);
	import ocu_pkg::*;

	logic                run_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	logic                flip_q;
	logic signed [31:0]  x_q;
	logic signed [31:0]  y_q;
	logic signed [32:0]  z_q;

	logic [31:0]         a_turn;
	logic                a_flip;
	logic [31:0]         a_fold;
	logic signed [31:0]  dx;
	logic signed [31:0]  dy;
	logic signed [32:0]  at;
	logic                last;

	always_comb begin
		a_turn = 32'(angle) << TURN_SHIFT;
		a_flip = a_turn[31] ^ a_turn[30];
		// second and third quadrant: rotate by half a turn, negate at the end
		a_fold = a_flip ? {~a_turn[31], a_turn[30:0]} : a_turn;
		dx     = y_q >>> step_q;
		dy     = x_q >>> step_q;
		at     = signed'({1'b0, atan_turn(step_q)});
		last   = (step_q == STEP_W'(CORDIC_STEPS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (last) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= 33'(signed'(a_fold));
			flip_q <= a_flip;
		end else if (run_q) begin
			if (!z_q[32]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign done  = done_q;
	assign cos_v = flip_q ? -x_q : x_q;
	assign sin_v = flip_q ? -y_q : y_q;

endmodule

FILE: rtl/ocu_mul.sv
// ----------------------------------------------------------------------------
// ocu_mul: shared multiplier
// Registered signed product with Q30 and direction rounding on the output.
// ----------------------------------------------------------------------------
module ocu_mul (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ocu_pkg::mul_op_t                 op,
	input  logic signed [ocu_pkg::MA_W-1:0]  a,
	input  logic signed [31:0]               b,
	output ocu_pkg::mul_res_t                res
);
	import ocu_pkg::*;

	localparam logic signed [P_W-1:0] HALF_Q30 = P_W'(1) << 29;
	localparam logic signed [P_W-1:0] HALF_Q45 = P_W'(1) << 44;

	logic                  valid_s1;
	logic [2:0]            tag_s1;
	logic                  neg_s1;
	logic signed [P_W-1:0] p_s1;

	logic signed [P_W-1:0]   r30;
	logic signed [P_W-1:0]   r45;
	logic signed [DIR_W-1:0] d;
	logic signed [DIR_W-1:0] dn;
	logic signed [15:0]      dsat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= op.go;
		end
	end

	always_ff @(posedge clk) begin
		if (op.go) begin
			p_s1   <= a * b;
			tag_s1 <= op.tag;
			neg_s1 <= op.neg;
		end
	end

	always_comb begin
		r30 = p_s1 + HALF_Q30;
		r45 = p_s1 + HALF_Q45;
		d   = DIR_W'(signed'(r45[P_W-1:45]));
		dn  = neg_s1 ? -d : d;
		priority if (dn > DIR_W'(signed'(16'h7FFF))) begin
			dsat = signed'(16'h7FFF);
		end else if (dn < DIR_W'(signed'(16'h8000))) begin
			dsat = signed'(16'h8000);
		end else begin
			dsat = dn[15:0];
		end
		res.valid = valid_s1;
		res.tag   = tag_s1;
		res.q30   = signed'(r30[P_W-1:30]);
		res.dir   = dsat;
	end

endmodule

FILE: rtl/orbit_camera_update.sv
// ----------------------------------------------------------------------------
// orbit_camera_update: orbit camera position and view direction
// Keeps azimuth, declination, radius and spin; answers every word with the
// Cartesian position and the unit view direction toward the origin.
// ----------------------------------------------------------------------------
//
//  channel  | signals                       | word
//  ---------+-------------------------------+-----------------------------
//  request  | req_valid, req_stall, req_data | move or reload command
//  response | rsp_valid, rsp_stall, rsp_data | position, direction, flag
//  config   | cfg_we, cfg_index, cfg_data    | start point registers
//
//  Between acceptance and a loaded response register, one word runs through
//  two 30-step passes on the shared CORDIC rotator (declination, then
//  azimuth) and six products on the shared 33x32 multiplier.
//  The next word can be accepted in the cycle after the load.
//  req_stall is high from acceptance until the response register is loaded.
//  rsp_stall holds the response; a finished word then waits in the last step.
//  Reset loads the start registers with their reset values and the camera
//  with that start point, spin cleared.
//
// ----------------------------------------------------------------------------
module orbit_camera_update (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ocu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ocu_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  ocu_pkg::req_t                  req_data,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output ocu_pkg::rsp_t                  rsp_data
);
	import ocu_pkg::*;

	// sequencer states
	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_APPLY   = 3'd1;
	localparam logic [2:0] ST_CD_GO   = 3'd2;
	localparam logic [2:0] ST_CD_WAIT = 3'd3;
	localparam logic [2:0] ST_CA_WAIT = 3'd4;
	localparam logic [2:0] ST_MUL     = 3'd5;
	localparam logic [2:0] ST_DRAIN   = 3'd6;
	localparam logic [2:0] ST_DONE    = 3'd7;

	logic [2:0]                    state_q;
	logic [2:0]                    state_n;
	logic [2:0]                    mstep_q;

	// camera state
	logic [ANGLE_BITS-1:0]         azimuth;
	logic [ANGLE_BITS-1:0]         declination;
	logic signed [RADIUS_BITS-1:0] radius;
	logic                          capture;
	logic                          apply;

	// rotator
	logic                          cor_start;
	logic [ANGLE_BITS-1:0]         cor_angle;
	logic                          cor_done;
	logic signed [31:0]            cor_cos;
	logic signed [31:0]            cor_sin;
	logic signed [31:0]            cd_q;
	logic signed [31:0]            sd_q;
	logic signed [31:0]            ca_q;
	logic signed [31:0]            sa_q;

	// multiplier
	mul_op_t                       mop;
	logic signed [MA_W-1:0]        ma;
	logic signed [31:0]            mb;
	mul_res_t                      mres;
	logic signed [31:0]            pos_sat;

	// products
	logic signed [RS_W-1:0]        rs_q;
	logic signed [31:0]            px_q;
	logic signed [31:0]            py_q;
	logic signed [31:0]            pz_q;
	logic signed [15:0]            dx_q;
	logic signed [15:0]            dy_q;

	// direction z straight from cos(declination)
	logic signed [32:0]            dz_sum;
	logic signed [18:0]            dz;
	logic signed [18:0]            dz_n;
	logic signed [15:0]            dz_sat;

	logic                          rad_zero;
	logic                          rad_pos;
	logic                          out_free;
	logic                          rsp_valid_q;
	rsp_t                          rsp_q;

	ocu_state u_state (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.capture     (capture),
		.req_data    (req_data),
		.apply       (apply),
		.azimuth     (azimuth),
		.declination (declination),
		.radius      (radius)
	);

	ocu_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.angle  (cor_angle),
		.done   (cor_done),
		.cos_v  (cor_cos),
		.sin_v  (cor_sin)
	);

	ocu_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (mop),
		.a      (ma),
		.b      (mb),
		.res    (mres)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign capture   = req_valid && (state_q == ST_IDLE);
	assign apply     = (state_q == ST_APPLY);
	assign rad_zero  = (radius == '0);
	assign rad_pos   = !radius[RADIUS_BITS-1] && !rad_zero;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// declination pass first, azimuth pass started on its completion
	assign cor_start = (state_q == ST_CD_GO) || ((state_q == ST_CD_WAIT) && cor_done);
	assign cor_angle = (state_q == ST_CD_GO) ? declination : azimuth;

	// product schedule: rs first so it is back before px and py issue
	always_comb begin
		mop.go  = (state_q == ST_MUL);
		mop.tag = mstep_q;
		mop.neg = rad_pos;
		unique case (mstep_q)
			MT_RS: begin ma = MA_W'(radius); mb = sd_q; end
			MT_PZ: begin ma = MA_W'(radius); mb = cd_q; end
			MT_DX: begin ma = MA_W'(sd_q);   mb = ca_q; end
			MT_DY: begin ma = MA_W'(sd_q);   mb = sa_q; end
			MT_PX: begin ma = MA_W'(rs_q);   mb = ca_q; end
			MT_PY: begin ma = MA_W'(rs_q);   mb = sa_q; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	// position clamp to 32 bits
	always_comb begin
		priority if (mres.q30 > Q_W'(signed'(32'h7FFF_FFFF))) begin
			pos_sat = signed'(32'h7FFF_FFFF);
		end else if (mres.q30 < Q_W'(signed'(32'h8000_0000))) begin
			pos_sat = signed'(32'h8000_0000);
		end else begin
			pos_sat = mres.q30[31:0];
		end
	end

	// dir_z: cd * 2^30 rounded to Q1.15 is a plain rounding shift
	always_comb begin
		dz_sum = 33'(cd_q) + 33'sd16384;
		dz     = 19'(signed'(dz_sum[32:15]));
		dz_n   = rad_pos ? -dz : dz;
		priority if (dz_n > 19'(signed'(16'h7FFF))) begin
			dz_sat = signed'(16'h7FFF);
		end else if (dz_n < 19'(signed'(16'h8000))) begin
			dz_sat = signed'(16'h8000);
		end else begin
			dz_sat = dz_n[15:0];
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE:    if (req_valid) state_n = ST_APPLY;
			ST_APPLY:   state_n = ST_CD_GO;
			ST_CD_GO:   state_n = ST_CD_WAIT;
			ST_CD_WAIT: if (cor_done) state_n = ST_CA_WAIT;
			ST_CA_WAIT: if (cor_done) state_n = ST_MUL;
			ST_MUL:     if (mstep_q == MT_PY) state_n = ST_DRAIN;
			ST_DRAIN:   state_n = ST_DONE;
			ST_DONE:    if (out_free) state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mstep_q <= MT_RS;
		end else begin
			state_q <= state_n;
			if (state_q == ST_MUL) begin
				mstep_q <= mstep_q + 1'b1;
			end else begin
				mstep_q <= MT_RS;
			end
		end
	end

	// sine/cosine capture
	always_ff @(posedge clk) begin
		if (cor_done) begin
			if (state_q == ST_CD_WAIT) begin
				cd_q <= cor_cos;
				sd_q <= cor_sin;
			end else begin
				ca_q <= cor_cos;
				sa_q <= cor_sin;
			end
		end
	end

	// product capture, in the cycle after issue
	always_ff @(posedge clk) begin
		if (mres.valid) begin
			unique case (mres.tag)
				MT_RS: rs_q <= mres.q30[RS_W-1:0];
				MT_PZ: pz_q <= pos_sat;
				MT_DX: dx_q <= mres.dir;
				MT_DY: dy_q <= mres.dir;
				MT_PX: px_q <= pos_sat;
				MT_PY: py_q <= pos_sat;
				default: ;
			endcase
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			rsp_q.pos_x       <= px_q;
			rsp_q.pos_y       <= py_q;
			rsp_q.pos_z       <= pz_q;
			rsp_q.dir_x       <= rad_zero ? 16'sd0 : dx_q;
			rsp_q.dir_y       <= rad_zero ? 16'sd0 : dy_q;
			rsp_q.dir_z       <= rad_zero ? 16'sd0 : dz_sat;
			rsp_q.radius_zero <= rad_zero;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

`ifndef SYNTHESIS
	a_accept_applies: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == ST_APPLY))
		else $error("accepted word not applied next cycle");

	a_cordic_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> (state_q == ST_CD_WAIT || state_q == ST_CA_WAIT))
		else $error("rotator finished outside a wait step");

	a_mul_result_window: assert property (@(posedge clk) disable iff (!arst_n)
		mres.valid |-> (state_q == ST_MUL || state_q == ST_DRAIN))
		else $error("product returned outside the product steps");

	a_zero_radius_dir: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.radius_zero) |->
		(rsp_data.dir_x == 16'sd0 && rsp_data.dir_y == 16'sd0 &&
		 rsp_data.dir_z == 16'sd0))
		else $error("zero radius with nonzero direction");
`endif

endmodule

FILE: verif/tb_orbit_camera_update.sv
// ----------------------------------------------------------------------------
// tb_orbit_camera_update: self-checking bench for the orbit camera update
// A directed table walks the radius, declination, azimuth, spin and reload corners,
// then random words run under several start points. Every response word is
// compared field by field with a bit-exact camera predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_orbit_camera_update;

	import ocu_pkg::*;

	localparam int     ITEMS_PER_PHASE = 171;
	localparam int     PHASES          = 6;
	localparam int     HOLD_CYCLES     = 400;
	localparam int     CYCLE_LIMIT     = 600000;
	localparam int     DRAIN_CYCLES    = 100;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// angle arithmetic, 2^32 units per turn scaled down to ANGLE_BITS
	localparam int     TURN_SH    = 32 - ANGLE_BITS;
	localparam longint ANG_MASK   = (64'sd1 <<< ANGLE_BITS) - 1;
	localparam longint SPIN_ANG   = (((64'sd6835653 <<< 1) >>> TURN_SH) + 1) >>> 1;
	localparam longint DECL_LIMIT = (((64'sd2147078531 <<< 1) >>> TURN_SH) + 1) >>> 1;
	localparam longint CORDIC_K   = 64'sd652032874;

	typedef struct packed {
		longint c;
		longint s;
	} cs_t;

	typedef struct packed {
		req_t word;
		logic zero_view;
	} row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	req_t                  req_data  = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	rsp_t                  rsp_data;

	// arctangent of 2^-i, 2^32 units per turn
	longint atan_steps [30] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
		81, 41, 20, 10, 5, 3, 1
	};

	// camera state and start point as the block should hold them
	longint cam_az    = 0;
	longint cam_dec   = 4194304;
	longint cam_rad   = 655360;
	longint cam_spin  = 0;
	longint start_az  = 0;
	longint start_dec = 4194304;
	longint start_rad = 655360;

	rsp_t   expected_views [$];
	row_t   directed_rows [$];
	int     mismatches = 0;
	int     cycles     = 0;
	bit     idle_en    = 1'b1;
	bit     hold_go    = 1'b0;
	bit     hold_done  = 1'b0;
	int     hold_left  = 0;
	int     stall_left = 0;

	orbit_camera_update dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	always #5 clk = ~clk;

	function automatic longint clamp_bits(input longint v, input int w);
		longint hi;
		longint lo;
		hi = (64'sd1 <<< (w - 1)) - 1;
		lo = -hi - 1;
		return (v > hi) ? hi : ((v < lo) ? lo : v);
	endfunction

	// (a * b) / 2^30, rounded half up
	function automatic longint mul_q30(input longint a, input longint b);
		logic signed [127:0] wa;
		logic signed [127:0] wb;
		logic signed [127:0] p;
		wa = a;
		wb = b;
		p = wa * wb + (128'sd1 <<< 29);
		return longint'(p >>> 30);
	endfunction

	// cosine and sine in Q1.30; the left half-plane is folded by a half turn
	function automatic cs_t rotate_angle(input longint ang);
		cs_t    r;
		longint a;
		longint t;
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		bit     flip;
		a = (ang <<< TURN_SH) & 64'hFFFF_FFFF;
		t = a + 64'h4000_0000;
		flip = t[31];
		if (flip) begin
			a = (a + 64'h8000_0000) & 64'hFFFF_FFFF;
		end
		z = longint'(int'(a[31:0]));
		x = CORDIC_K;
		y = 0;
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= atan_steps[i];
			end else begin
				x += dx;
				y -= dy;
				z += atan_steps[i];
			end
		end
		r.c = flip ? -x : x;
		r.s = flip ? -y : y;
		return r;
	endfunction

	// Q2.60 product to Q1.15, pointing back toward the origin
	function automatic logic signed [15:0] dir_part(input longint prod, input bit outward);
		longint v;
		v = (prod + (64'sd1 <<< 44)) >>> 45;
		if (outward) begin
			v = -v;
		end
		return 16'(clamp_bits(v, 16));
	endfunction

	// advance the camera by one word and return the view it should report
	function automatic rsp_t orbit_step(input req_t w);
		rsp_t   r;
		cs_t    d;
		cs_t    a;
		longint dec;
		longint rs;
		if (w.func == FUNC_RELOAD) begin
			cam_az   = start_az;
			cam_dec  = start_dec;
			cam_rad  = start_rad;
			cam_spin = 0;
		end else begin
			cam_spin = (cam_spin + longint'(w.spin_step) * SPIN_ANG) & ANG_MASK;
			cam_az   = (cam_az + longint'(w.delta_azimuth) + cam_spin) & ANG_MASK;
			dec = cam_dec + longint'(w.delta_declination);
			// below the pole snaps to 0.01 rad; an exact zero is kept
			if (dec < 0) begin
				dec = SPIN_ANG;
			end else if (dec > DECL_LIMIT) begin
				dec = DECL_LIMIT;
			end
			cam_dec = dec & ANG_MASK;
			cam_rad = clamp_bits(cam_rad - longint'(w.delta_radius), RADIUS_BITS);
		end
		d = rotate_angle(cam_dec);
		a = rotate_angle(cam_az);
		rs = mul_q30(cam_rad, d.s);
		r.pos_x = 32'(clamp_bits(mul_q30(rs, a.c), 32));
		r.pos_y = 32'(clamp_bits(mul_q30(rs, a.s), 32));
		r.pos_z = 32'(clamp_bits(mul_q30(cam_rad, d.c), 32));
		if (cam_rad == 0) begin
			r.dir_x = '0;
			r.dir_y = '0;
			r.dir_z = '0;
			r.radius_zero = 1'b1;
		end else begin
			r.dir_x = dir_part(d.s * a.c, cam_rad > 0);
			r.dir_y = dir_part(d.s * a.s, cam_rad > 0);
			r.dir_z = dir_part(d.c * (64'sd1 <<< 30), cam_rad > 0);
			r.radius_zero = 1'b0;
		end
		return r;
	endfunction

	// mostly small moves; now and then a full-range or extreme field
	function automatic longint pick(input int w, input int span);
		longint top;
		top = (64'sd1 <<< (w - 1)) - 1;
		case ($urandom_range(0, 9))
			0: return {$urandom, $urandom};
			1: return $urandom_range(0, 1) ? top : -top - 1;
			default: return longint'($urandom_range(0, 2 * span)) - span;
		endcase
	endfunction

	function automatic req_t random_word();
		req_t w;
		w.func              = ($urandom_range(0, 99) < 8) ? FUNC_RELOAD : FUNC_MOVE;
		w.delta_declination = 24'(pick(24, 1 << 16));
		w.delta_azimuth     = 24'(pick(24, 1 << 20));
		w.delta_radius      = 32'(pick(32, 1 << 16));
		w.spin_step         = 16'(pick(16, 3));
		return w;
	endfunction

	function automatic void row(input logic func, input longint dd, input longint da,
		input longint dr, input longint st, input logic zero_view);
		row_t r;
		r.word.func              = func;
		r.word.delta_declination = 24'(dd);
		r.word.delta_azimuth     = 24'(da);
		r.word.delta_radius      = 32'(dr);
		r.word.spin_step         = 16'(st);
		r.zero_view              = zero_view;
		directed_rows.push_back(r);
	endfunction

	function automatic void match_field(input string name, input logic signed [31:0] want,
		input logic signed [31:0] got);
		if (got !== want) begin
			$display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	task automatic check_view(input rsp_t got);
		rsp_t want;
		if (expected_views.size() == 0) begin
			$display("%0t unexpected word: expected none, actual pos %0d %0d %0d",
				$time, got.pos_x, got.pos_y, got.pos_z);
			mismatches++;
			return;
		end
		want = expected_views.pop_front();
		match_field("pos_x", want.pos_x, got.pos_x);
		match_field("pos_y", want.pos_y, got.pos_y);
		match_field("pos_z", want.pos_z, got.pos_z);
		match_field("dir_x", want.dir_x, got.dir_x);
		match_field("dir_y", want.dir_y, got.dir_y);
		match_field("dir_z", want.dir_z, got.dir_z);
		match_field("radius_zero", want.radius_zero, got.radius_zero);
	endtask

	// expectation is queued before valid rises, so it is always ahead of the response
	task automatic send_word(input req_t w, input logic zero_view);
		rsp_t want;
		if (idle_en && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		want = orbit_step(w);
		if (zero_view) begin
			want = '0;
			want.radius_zero = 1'b1;
		end
		expected_views.push_back(want);
		req_valid <= 1'b1;
		req_data  <= w;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (expected_views.size() != 0) @(posedge clk);
	endtask

	// all registers in one burst, with a write to the unused index in between
	task automatic set_start_point(input logic [31:0] az, input logic [31:0] dec,
		input logic [31:0] rad);
		cfg_we    <= 1'b1;
		cfg_index <= REG_START_AZ;
		cfg_data  <= az;
		@(posedge clk);
		cfg_index <= REG_UNUSED;
		cfg_data  <= $urandom;
		@(posedge clk);
		cfg_index <= REG_START_DEC;
		cfg_data  <= dec;
		@(posedge clk);
		cfg_index <= REG_START_RAD;
		cfg_data  <= rad;
		@(posedge clk);
		cfg_we <= 1'b0;
		start_az  = longint'(az[23:0]) & ANG_MASK;
		start_dec = longint'(dec[23:0]) & ANG_MASK;
		start_rad = clamp_bits(longint'(int'(rad)), RADIUS_BITS);
	endtask

	// response side: checks, random stall bursts, and one long hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) check_view(rsp_data);
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (stall_left == 0 && idle_en && $urandom_range(0, 9) == 0)
				stall_left = $urandom_range(1, 16);
			if (hold_left != 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		logic [31:0] az;
		logic [31:0] dec;
		logic [31:0] rad;

		// reset start point: azimuth 0, declination a quarter turn, radius 10.0
		row(FUNC_RELOAD, 0, 0, 0, 0, 1'b0);
		row(FUNC_MOVE, 0, 0, 0, 0, 1'b0);
		row(FUNC_MOVE, 0, 0, 655360, 0, 1'b1);         // radius to zero
		row(FUNC_MOVE, 0, 0, 0, 0, 1'b1);              // still zero
		row(FUNC_MOVE, 0, 0, -64'sd2147483648, 0, 1'b0); // saturates high
		row(FUNC_MOVE, 0, 0, -64'sd2147483648, 0, 1'b0);
		row(FUNC_MOVE, 0, 0, 2147483647, 0, 1'b1);     // max minus max
		row(FUNC_MOVE, 0, 0, 2147483647, 0, 1'b0);     // negative radius
		row(FUNC_MOVE, 0, 0, 2147483647, 0, 1'b0);     // saturates low
		row(FUNC_MOVE, 0, 0, -64'sd2147483648, 0, 1'b1); // min minus min
		row(FUNC_MOVE, 0, 0, -655360, 0, 1'b0);
		row(FUNC_MOVE, -8388608, 0, 0, 0, 1'b0);       // below the pole
		row(FUNC_MOVE, -SPIN_ANG, 0, 0, 0, 1'b0);      // lands on exactly zero
		row(FUNC_MOVE, 8388607, 0, 0, 0, 1'b0);        // past 3.141 rad
		row(FUNC_MOVE, 8388607, 0, 0, 0, 1'b0);
		row(FUNC_MOVE, 0, 8388607, 0, 0, 1'b0);
		row(FUNC_MOVE, 0, -8388608, 0, 0, 1'b0);
		row(FUNC_MOVE, 0, 0, 0, 32767, 1'b0);
		row(FUNC_MOVE, 0, 0, 0, -32768, 1'b0);
		row(FUNC_MOVE, 0, 0, 0, -1, 1'b0);
		row(FUNC_RELOAD, -1, -1, -1, -1, 1'b0);        // deltas ignored, spin cleared
		row(FUNC_MOVE, 0, 0, 0, 0, 1'b0);
		row(FUNC_MOVE, -4194304, 8388607, 0, 1, 1'b0);
		row(FUNC_MOVE, 1, 0, 1, 0, 1'b0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) send_word(directed_rows[i].word, directed_rows[i].zero_view);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					// full-turn azimuth with junk above the register, half-turn declination
					az  = 32'hFFFF_FFFF;
					dec = 32'd8388608;
					rad = 32'h7FFF_FFFF;
				end
				1: begin
					az  = 32'h0;
					dec = 32'h0;
					rad = 32'h8000_0000;
				end
				2: begin
					az  = $urandom;
					dec = 32'($urandom_range(0, 8388608));
					rad = 32'h0;
				end
				default: begin
					az  = $urandom;
					dec = {8'($urandom), 24'($urandom_range(0, 8388608))};
					rad = $urandom_range(0, 1) ? $urandom :
						32'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
				end
			endcase
			idle_en = (ph != 1 && ph != PHASES - 1);
			set_start_point(az, dec, rad);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == 3 && n == 20) hold_go = 1'b1;
				send_word(random_word(), 1'b0);
			end
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
